// ----- src/tdfsm_pkg.sv -----
// Shared types, constants and helpers for the table-driven state machine engine.
// Used by tdfsm_ctrl and the top level; depends on nothing else.

package tdfsm_pkg;

    localparam int TABLE_ENTRIES  = 16;
    localparam int STATE_COUNT    = 16;
    localparam int EVENT_COUNT    = 16;
    localparam int CONDITION_BITS = 8;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EVENT = 2'd2;

    localparam logic [1:0] CFG_INITIAL = 2'd0;
    localparam logic [1:0] CFG_FINAL   = 2'd1;
    localparam logic [1:0] CFG_COUNT   = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [3:0] entry_index;
        logic [3:0] entry_source;
        logic       entry_source_any;
        logic [3:0] entry_event;
        logic       entry_event_any;
        logic [2:0] entry_cond_select;
        logic       entry_cond_used;
        logic [3:0] entry_target;
        logic [3:0] event_code;
        logic [7:0] cond_flags;
    } t_in_item;

    typedef struct packed {
        logic       fired;
        logic [3:0] fired_entry;
        logic [3:0] prev_state;
        logic [3:0] new_state;
        logic       finished;
    } t_out_item;

    typedef struct packed {
        logic [3:0] initial_state;
        logic [3:0] final_state;
        logic [4:0] entries_in_use;
    } t_cfg;

    typedef struct packed {
        logic [3:0] source;
        logic       source_any;
        logic [3:0] event_code;
        logic       event_any;
        logic [2:0] cond_select;
        logic       cond_used;
        logic [3:0] target;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_FINISH,
        S_HOLD
    } t_state;

    function automatic logic [3:0] clamp_state(input logic [3:0] s);
        if (int'(s) >= STATE_COUNT) begin
            return 4'(STATE_COUNT - 1);
        end
        return s;
    endfunction

endpackage

// ----- src/tdfsm_ram.sv -----
// Generic single-write, single-read synchronous RAM with a registered read port.
// Standalone; no package needed.

module tdfsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/tdfsm_ctrl.sv -----
// Request sequencer: holds the machine state, scans the transition table RAM
// one entry per cycle and builds the result. Depends on tdfsm_pkg and tdfsm_ram.

module tdfsm_ctrl import tdfsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    input  logic      i_take,
    output logic      o_done,
    output t_out_item o_res
);

    t_state              r_state, n_state;
    logic [3:0]          r_cur, n_cur;
    logic                r_run, n_run;
    logic [1:0]          r_cmd;
    logic [3:0]          r_ev;
    logic [7:0]          r_flags;
    logic [IDX_W-1:0]    r_idx, n_idx;
    t_out_item           r_res;

    t_entry              rd_entry;
    logic [IDX_W-1:0]    raddr;
    logic                accept;
    logic                eligible;
    logic                wr_en;
    t_entry              wr_entry;
    logic                hit;
    logic                last;
    logic [CNT_W-1:0]    scan_cnt;
    logic                done;
    t_out_item           res;

    function automatic logic entry_match(input t_entry e, input logic [3:0] cur,
                                         input logic [3:0] ev, input logic [7:0] fl);
        logic m;
        m = 1'b1;
        if (!e.source_any && e.source != cur) begin
            m = 1'b0;
        end
        if (!e.event_any && e.event_code != ev) begin
            m = 1'b0;
        end
        if (e.cond_used) begin
            if (int'(e.cond_select) >= CONDITION_BITS) begin
                m = 1'b0;
            end else if (!fl[e.cond_select]) begin
                m = 1'b0;
            end
        end
        return m;
    endfunction

    assign scan_cnt = (int'(i_cfg.entries_in_use) > TABLE_ENTRIES) ?
                      CNT_W'(TABLE_ENTRIES) : CNT_W'(i_cfg.entries_in_use);

    assign accept = i_valid && (r_state == S_IDLE);

    assign eligible = (i_item.cmd == CMD_EVENT) && r_run &&
                      (r_cur != i_cfg.final_state) &&
                      (int'(i_item.event_code) < EVENT_COUNT) &&
                      (scan_cnt != '0);

    // Table writes land at acceptance; no scan can be in flight then.
    assign wr_en = accept && (i_item.cmd == CMD_WRITE) &&
                   (int'(i_item.entry_index) < TABLE_ENTRIES);

    always_comb begin
        wr_entry.source      = i_item.entry_source;
        wr_entry.source_any  = i_item.entry_source_any;
        wr_entry.event_code  = i_item.entry_event;
        wr_entry.event_any   = i_item.entry_event_any;
        wr_entry.cond_select = i_item.entry_cond_select;
        wr_entry.cond_used   = i_item.entry_cond_used;
        wr_entry.target      = clamp_state(i_item.entry_target);
    end

    tdfsm_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (i_item.entry_index[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (raddr),
        .o_rdata (rd_entry)
    );

    assign hit  = entry_match(rd_entry, r_cur, r_ev, r_flags);
    assign last = (CNT_W'(r_idx) + CNT_W'(1)) >= scan_cnt;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = eligible ? S_CHECK : S_FINISH;
                end
            end
            S_CHECK: begin
                if (hit || last) begin
                    n_state = i_take ? S_IDLE : S_HOLD;
                end
            end
            S_FINISH: begin
                n_state = i_take ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs, RAM read address and machine state update.
    always_comb begin
        raddr = '0;
        n_idx = r_idx;
        n_cur = r_cur;
        n_run = r_run;
        done  = 1'b0;
        res   = r_res;
        case (r_state)
            S_IDLE: begin
                raddr = '0;
                n_idx = '0;
            end
            S_CHECK: begin
                raddr = r_idx + IDX_W'(1);
                done  = hit || last;
                if (!hit && !last) begin
                    n_idx = r_idx + IDX_W'(1);
                end
                if (hit) begin
                    n_cur = rd_entry.target;
                end
                res.fired       = hit;
                res.fired_entry = hit ? 4'(r_idx) : 4'd0;
                res.prev_state  = r_cur;
                res.new_state   = n_cur;
                res.finished    = n_run && (n_cur == i_cfg.final_state);
            end
            S_FINISH: begin
                done = 1'b1;
                if (r_cmd == CMD_START) begin
                    n_cur = clamp_state(i_cfg.initial_state);
                    n_run = 1'b1;
                end
                res.fired       = 1'b0;
                res.fired_entry = 4'd0;
                res.prev_state  = r_cur;
                res.new_state   = n_cur;
                res.finished    = n_run && (n_cur == i_cfg.final_state);
            end
            S_HOLD: begin
                done = 1'b1;
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= '0;
            r_run   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_run   <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (accept) begin
            r_cmd   <= i_item.cmd;
            r_ev    <= i_item.event_code;
            r_flags <= i_item.cond_flags;
        end
        if (done) begin
            r_res <= res;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_done  = done;
    assign o_res   = res;

endmodule

// ----- src/table_driven_fsm_engine_unit.sv -----
// Top level of the table-driven state machine engine: configuration registers,
// result output register and the scan sequencer. Depends on tdfsm_pkg, tdfsm_ctrl.
//
//  Channel   Handshake                         Payload
//  input     i_in_valid / o_in_ready           i_in_item  (t_in_item)
//  output    o_out_valid / i_out_ready         o_out_item (t_out_item)
//  config    i_cfg_we (no wait)                i_cfg_idx, i_cfg_data
//
// A write, start or unused request passes through S_FINISH to the output
// register. So does an event that is not taken or has no entries to scan.
// Any other event is scanned in S_CHECK, reading table entries in order through
// the single read port of the table RAM until a hit or the last entry in use.
// One request is in flight at a time; the next is taken once the result has
// moved to the output register, even while that register still waits.
// Reset clears the machine state and resets the configuration, not the table.

module table_driven_fsm_engine_unit import tdfsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item,
    input  logic      i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [4:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out;
    logic      take;
    logic      done;
    t_out_item res;

    assign take = !r_out_valid || i_out_ready;

    tdfsm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_cfg   (r_cfg),
        .i_take  (take),
        .o_done  (done),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_state  <= 4'd0;
            r_cfg.final_state    <= 4'd15;
            r_cfg.entries_in_use <= 5'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INITIAL: r_cfg.initial_state  <= i_cfg_data[3:0];
                CFG_FINAL:   r_cfg.final_state    <= i_cfg_data[3:0];
                CFG_COUNT:   r_cfg.entries_in_use <= i_cfg_data;
                default:     r_cfg                <= r_cfg;
            endcase
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (done && take) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && take) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
